// ===== src/md5_pkg.sv =====
`default_nettype none
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // Command passed from the front end to the round engine
    typedef enum logic [1:0] {
        CMD_BLOCK  = 2'd0,  // compress buffer, keep running
        CMD_PAD    = 2'd1,  // compress buffer, then a length-only block
        CMD_FINAL  = 2'd2   // compress buffer as the final block
    } md5_cmd_t;

    typedef struct packed {
        md5_cmd_t     cmd;
        logic         buf_sel;
        logic [63:0]  bit_len;
    } md5_job_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_ROUND,
        ENG_ADD,
        ENG_EMIT
    } md5_eng_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [3:0] round_g(input logic [5:0] r);
        logic [3:0] g;
        begin
            unique case (r[5:4])
                2'd0:    g = r[3:0];
                2'd1:    g = 4'(5 * r[3:0] + 1);
                2'd2:    g = 4'(3 * r[3:0] + 5);
                2'd3:    g = 4'(7 * r[3:0]);
                default: g = r[3:0];
            endcase
            return g;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/md5_front.sv =====
`default_nettype none
module md5_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        data_byte,
    input  wire logic              byte_present,
    input  wire logic              end_of_message,
    input  wire logic              in_valid,
    output logic                   in_ready,
    // job output handshake
    output logic                   job_valid,
    input  wire logic              job_ready,
    output md5_pkg::md5_job_t      job,
    // buffer write port
    output logic                   wr_en,
    output logic                   wr_sel,
    output logic [5:0]             wr_pos,
    output logic [7:0]             wr_byte,
    input  wire logic [1:0]        buf_free
);
    import md5_pkg::*;

    logic [60:0] count_reg, count_next;
    logic        sel_reg, sel_next;
    // padding in progress: write 0x80 then zeros up to byte 55 or 63
    logic        pad_reg, pad_next;
    logic [5:0]  pad_pos_reg, pad_pos_next;
    logic        pad_first_reg, pad_first_next;
    logic        issue;

    assign in_ready = !pad_reg && buf_free[sel_reg] && job_ready;

    always_comb
    begin
        count_next     = count_reg;
        sel_next       = sel_reg;
        pad_next       = pad_reg;
        pad_pos_next   = pad_pos_reg;
        pad_first_next = pad_first_reg;
        wr_en   = 1'b0;
        wr_pos  = count_reg[5:0];
        wr_byte = data_byte;
        issue   = 1'b0;
        job.cmd = CMD_BLOCK;
        job.buf_sel = sel_reg;
        job.bit_len = {count_reg, 3'b000};
        if (pad_reg)
        begin
            // hold padding until the buffer is free and the queue has room
            if (buf_free[sel_reg] && job_ready)
            begin
                wr_en   = 1'b1;
                wr_pos  = pad_pos_reg;
                wr_byte = pad_first_reg ? PAD_BYTE : 8'h00;
                pad_first_next = 1'b0;
                pad_pos_next = pad_pos_reg + 6'd1;
                if ((pad_pos_reg == 6'd55 && count_reg[5:0] < 6'd56) || pad_pos_reg == 6'd63)
                begin
                    issue   = 1'b1;
                    job.cmd = (count_reg[5:0] < 6'd56) ? CMD_FINAL : CMD_PAD;
                    pad_next = 1'b0;
                    count_next = '0;
                    sel_next = !sel_reg;
                end
            end
        end
        else if (in_valid && in_ready)
        begin
            if (byte_present)
            begin
                wr_en = 1'b1;
                count_next = count_reg + 61'd1;
                if (count_reg[5:0] == 6'd63)
                begin
                    issue = 1'b1;
                    sel_next = !sel_reg;
                end
            end
            if (end_of_message)
            begin
                pad_next = 1'b1;
                pad_first_next = 1'b1;
                pad_pos_next = count_next[5:0];
                if (issue)
                    // block issued with this byte; its bit length counts this byte
                    job.bit_len = {count_next, 3'b000};
            end
        end
    end

    assign job_valid = issue;
    assign wr_sel    = sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sel_reg       <= 1'b0;
            pad_reg       <= 1'b0;
            pad_pos_reg   <= '0;
            pad_first_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sel_reg       <= sel_next;
            pad_reg       <= pad_next;
            pad_pos_reg   <= pad_pos_next;
            pad_first_reg <= pad_first_next;
        end
    end

    a_pad_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg |-> !in_ready) else $error("input taken during padding");
    a_issue_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> job_ready) else $error("job issued into full queue");
    a_pad_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (pad_reg && !pad_first_reg) |-> pad_pos_reg != count_reg[5:0])
        else $error("padding overwrote a message byte");

endmodule
`default_nettype wire

// ===== src/md5_engine.sv =====
`default_nettype none
module md5_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  md5_pkg::md5_job_t      job,
    input  wire logic              wr_en,
    input  wire logic              wr_sel,
    input  wire logic [5:0]        wr_pos,
    input  wire logic [7:0]        wr_byte,
    output logic [1:0]             buf_free,
    output logic [31:0]            out_word,
    output logic [1:0]             out_index,
    output logic                   out_valid,
    input  wire logic              out_ready
);
    import md5_pkg::*;

    // two block buffers of sixteen words, written a byte lane at a time
    logic [31:0] mem [0:31];
    logic [31:0] rd_word;

    // job queue, two deep
    md5_job_t    q_reg [0:1];
    logic        q_wp_reg, q_rp_reg;
    logic [1:0]  q_cnt_reg;

    logic [1:0]  busy_reg;          // buffer holds a block not yet compressed
    logic [1:0]  busy_next;
    md5_eng_state_t state_reg, state_next;
    logic [5:0]  rnd_reg;
    logic        len_pass_reg;      // running the length-only block
    md5_job_t    cur_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg;
    logic [1:0]  emit_reg;
    logic [5:0]  rd_rnd;
    logic [3:0]  g_idx;
    logic [31:0] m_word, f_val, sum, rot, b_new;
    logic        start, round_go, last_round, blk_done, emit_go;
    logic [31:0] len_word;
    logic [4:0]  rd_addr_w;

    assign job_ready = q_cnt_reg != 2'd2;
    assign buf_free  = ~busy_reg;
    assign start     = (state_reg == ENG_IDLE) && q_cnt_reg != 2'd0;

    // round r reads word g(r); the read is registered, so the address is presented in the cycle before the round
    assign rd_rnd    = start ? 6'd0 : rnd_reg + 6'd1;
    assign rd_addr_w = {start ? q_reg[q_rp_reg].buf_sel : cur_reg.buf_sel, round_g(rd_rnd)};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[{wr_sel, wr_pos[5:2]}][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
        rd_word <= mem[rd_addr_w];
    end

    assign g_idx = round_g(rnd_reg);
    assign len_word = (g_idx == 4'd14) ? cur_reg.bit_len[31:0] : cur_reg.bit_len[63:32];
    always_comb
    begin
        m_word = rd_word;
        if (len_pass_reg)
            m_word = (g_idx == 4'd14 || g_idx == 4'd15) ? len_word : 32'h0;
        else if (cur_reg.cmd == CMD_FINAL && (g_idx == 4'd14 || g_idx == 4'd15))
            m_word = len_word;
        unique case (rnd_reg[5:4])
            2'd0:    f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1:    f_val = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            2'd3:    f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = 32'h0;
        endcase
        sum = a_reg + f_val + round_k(rnd_reg) + m_word;
        rot = (sum << round_s(rnd_reg)) | (sum >> (6'd32 - {1'b0, round_s(rnd_reg)}));
        b_new = b_reg + rot;
    end

    assign round_go   = state_reg == ENG_ROUND;
    assign last_round = round_go && rnd_reg == 6'd63;
    assign blk_done   = state_reg == ENG_ADD;
    assign emit_go    = state_reg == ENG_EMIT && (!out_valid || out_ready);

    // buffer no longer needed once its last round has read it
    assign busy_next = (busy_reg | ({1'b0, job_valid} << job.buf_sel))
                     & ~({1'b0, last_round && !len_pass_reg} << cur_reg.buf_sel);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE:  if (start) state_next = ENG_ROUND;
            ENG_ROUND: if (last_round) state_next = ENG_ADD;
            ENG_ADD:
                if (cur_reg.cmd == CMD_PAD && !len_pass_reg)
                    state_next = ENG_ROUND;
                else if (cur_reg.cmd == CMD_BLOCK)
                    state_next = ENG_IDLE;
                else
                    state_next = ENG_EMIT;
            ENG_EMIT:  if (emit_go && emit_reg == 2'd3) state_next = ENG_IDLE;
            default:   state_next = ENG_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= '0;
            busy_reg  <= '0;
            rnd_reg   <= '0;
            len_pass_reg <= 1'b0;
            emit_reg  <= '0;
            out_valid <= 1'b0;
            h0_reg <= INIT_A; h1_reg <= INIT_B; h2_reg <= INIT_C; h3_reg <= INIT_D;
        end
        else
        begin
            state_reg <= state_next;
            if (job_valid)
                q_wp_reg <= !q_wp_reg;
            busy_reg  <= busy_next;
            q_cnt_reg <= q_cnt_reg + {1'b0, job_valid} - {1'b0, start};
            if (start)
                q_rp_reg <= !q_rp_reg;
            if (start || last_round)
                rnd_reg <= '0;
            else if (round_go)
                rnd_reg <= rnd_reg + 6'd1;
            if (start)
                len_pass_reg <= 1'b0;
            if (blk_done)
            begin
                if (cur_reg.cmd == CMD_PAD && !len_pass_reg)
                    len_pass_reg <= 1'b1;
                h0_reg <= h0_reg + a_reg; h1_reg <= h1_reg + b_reg;
                h2_reg <= h2_reg + c_reg; h3_reg <= h3_reg + d_reg;
            end
            if (emit_go)
            begin
                out_valid <= 1'b1;
                out_index <= emit_reg;
                unique case (emit_reg)
                    2'd0:    out_word <= h0_reg;
                    2'd1:    out_word <= h1_reg;
                    2'd2:    out_word <= h2_reg;
                    2'd3:    out_word <= h3_reg;
                    default: out_word <= h0_reg;
                endcase
                emit_reg <= emit_reg + 2'd1;
                if (emit_reg == 2'd3)
                begin
                    h0_reg <= INIT_A; h1_reg <= INIT_B;
                    h2_reg <= INIT_C; h3_reg <= INIT_D;
                end
            end
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid)
            q_reg[q_wp_reg] <= job;
        if (start)
            cur_reg <= q_reg[q_rp_reg];
        if (start)
        begin
            a_reg <= h0_reg; b_reg <= h1_reg; c_reg <= h2_reg; d_reg <= h3_reg;
        end
        else if (blk_done && state_next == ENG_ROUND)
        begin
            // length-only block starts from the freshly added chaining words
            a_reg <= h0_reg + a_reg; b_reg <= h1_reg + b_reg;
            c_reg <= h2_reg + c_reg; d_reg <= h3_reg + d_reg;
        end
        else if (round_go)
        begin
            a_reg <= d_reg; b_reg <= b_new; c_reg <= b_reg; d_reg <= c_reg;
        end
    end

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg != 2'd3) else $error("job queue count out of range");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg == ENG_ROUND) else $error("engine failed to start");
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_index == 2'd3) |=> !out_valid || out_index == 2'd0)
        else $error("digest words out of order");

endmodule
`default_nettype wire

// ===== src/md5_message_digest_top.sv =====
// MD5 digest of a byte stream.
// Input channel s_axis: one transaction per item. s_axis_tdata[7:0] is the
// message byte, s_axis_tuser marks it as present, s_axis_tlast ends the
// message. An item with tlast and no byte closes the message as it stands.
// Output channel m_axis: four transactions per message, digest words A..D;
// tuser carries the word index, tlast marks word D.
// Throughput: one byte per cycle while the current block buffer is free, the
// job queue has room and no padding is being written. Two 64-byte buffers
// alternate, so the front end fills one while the round engine compresses the
// other (a start step, one round a cycle and the chaining add). Closing a
// message takes padding writes, one or two block compressions and four
// output transactions.
// A two-entry job queue separates the byte front end from the round engine.
// Reset loads the standard initial chaining values and clears the count.
// When the receiver stalls, the engine holds the digest and, once its
// buffers are full, s_axis_tready falls.
`default_nettype none
module md5_message_digest_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] byte_present
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]       m_axis_tuser,   // [1:0] word_index
    output logic             m_axis_tlast    // last_word
);
    import md5_pkg::*;

    md5_job_t   job;
    logic       job_valid, job_ready;
    logic       wr_en, wr_sel;
    logic [5:0] wr_pos;
    logic [7:0] wr_byte;
    logic [1:0] buf_free;

    md5_front u_front (
        .clk, .rst_n,
        .data_byte(s_axis_tdata), .byte_present(s_axis_tuser),
        .end_of_message(s_axis_tlast),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .job_valid, .job_ready, .job,
        .wr_en, .wr_sel, .wr_pos, .wr_byte, .buf_free
    );

    md5_engine u_engine (
        .clk, .rst_n,
        .job_valid, .job_ready, .job,
        .wr_en, .wr_sel, .wr_pos, .wr_byte, .buf_free,
        .out_word(m_axis_tdata), .out_index(m_axis_tuser),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
    );

    assign m_axis_tlast = m_axis_tuser == 2'd3;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
    import md5_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    md5_message_digest_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eom;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_out_t;

    localparam int MAX_CYCLES = 400000;

    logic [31:0] addend [64];
    int unsigned rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [60:0] byte_cnt;

    digest_out_t digest_q[$];
    msg_item_t   stim_q[$];
    // known first digest word of each directed message, flag in the top bit
    logic [32:0] known_q[$];
    int          n_errors;
    int          n_words;
    int          n_msgs;
    longint      cycles;
    logic        all_sent;

    // Directed rows: the empty message and "a" have a known first digest word; the rest are predicted
    typedef struct {
        msg_item_t   item;
        logic        has_known;
        logic [31:0] known_a;
    } dir_row_t;

    function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic compress();
        logic [31:0] a, b, c, d, f, t, sum;
        int unsigned g;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                f = d ^ (b & (c ^ d)); g = r;
            end
            else if (r < 32)
            begin
                f = c ^ (d & (b ^ c)); g = (5 * r + 1) % 16;
            end
            else if (r < 48)
            begin
                f = b ^ c ^ d; g = (3 * r + 5) % 16;
            end
            else
            begin
                f = c ^ (b | ~d); g = (7 * r) % 16;
            end
            sum = a + f + addend[r] + blk[g];
            t = d; d = c; c = b;
            b = b + rotl(sum, rot[((r / 16) * 4) + (r % 4)]);
            a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic put_byte(int unsigned pos, logic [7:0] v);
        blk[pos / 4][(pos % 4) * 8 +: 8] = v;
    endtask

    task automatic restart_chain();
        chain[0] = INIT_A; chain[1] = INIT_B; chain[2] = INIT_C; chain[3] = INIT_D;
        byte_cnt = '0;
    endtask

    task automatic absorb(msg_item_t it);
        int unsigned pos;
        logic [63:0] bits;
        digest_out_t o;
        if (it.present)
        begin
            put_byte(byte_cnt[5:0], it.data);
            byte_cnt = byte_cnt + 1;
            if (byte_cnt[5:0] == 0)
                compress();
        end
        if (!it.eom)
            return;
        pos = byte_cnt[5:0];
        put_byte(pos, PAD_BYTE);
        for (int k = pos + 1; k < 64; k++)
            put_byte(k, 8'h00);
        if (pos >= 56)
        begin
            compress();
            for (int k = 0; k < 16; k++)
                blk[k] = '0;
        end
        bits = {byte_cnt, 3'b000};
        blk[14] = bits[31:0];
        blk[15] = bits[63:32];
        compress();
        for (int k = 0; k < 4; k++)
        begin
            o.word = chain[k];
            o.idx  = 2'(k);
            o.last = (k == 3);
            digest_q.push_back(o);
        end
        restart_chain();
    endtask

    function automatic msg_item_t mk(logic [7:0] d, logic p, logic e);
        msg_item_t it;
        it.data = d; it.present = p; it.eom = e;
        return it;
    endfunction

    task automatic add_message(int unsigned len, bit close_with_byte);
        for (int unsigned i = 0; i < len; i++)
        begin
            // scatter ignored items inside the message as noise
            if ($urandom_range(0, 15) == 0)
                stim_q.push_back(mk(8'($urandom), 1'b0, 1'b0));
            if (close_with_byte && i == len - 1)
                stim_q.push_back(mk(8'($urandom), 1'b1, 1'b1));
            else
                stim_q.push_back(mk(8'($urandom), 1'b1, 1'b0));
        end
        if (!close_with_byte || len == 0)
            stim_q.push_back(mk(8'($urandom), 1'b0, 1'b1));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender: bursts of random length, gaps of random length (sometimes none) between them
    initial
    begin
        msg_item_t it;
        int burst;
        int gap;
        dir_row_t dir [$];
        int unsigned lens [6] = '{1, 55, 56, 57, 63, 64};

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        all_sent      = 1'b0;
        restart_chain();
        for (int k = 0; k < 16; k++)
            blk[k] = '0;

        // Directed rows first, run through the same queue
        dir.push_back('{mk(8'h00, 1'b0, 1'b1), 1'b1, 32'hd98c1dd4});
        dir.push_back('{mk(8'hff, 1'b0, 1'b0), 1'b0, '0});
        dir.push_back('{mk(8'h61, 1'b1, 1'b1), 1'b1, 32'hb975c10c});
        dir.push_back('{mk(8'h00, 1'b1, 1'b0), 1'b0, '0});
        dir.push_back('{mk(8'hff, 1'b1, 1'b0), 1'b0, '0});
        dir.push_back('{mk(8'h5a, 1'b0, 1'b1), 1'b0, '0});
        foreach (dir[i])
        begin
            stim_q.push_back(dir[i].item);
            if (dir[i].item.eom)
                known_q.push_back({dir[i].has_known, dir[i].known_a});
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Messages of length 1 and around the padding boundaries, then random ones
        foreach (lens[i])
            add_message(lens[i], i % 2);
        while (stim_q.size() < 405)
        begin
            if ($urandom_range(0, 9) == 0)
                add_message($urandom_range(0, 40), $urandom_range(0, 1));
            else
                add_message($urandom_range(0, 12), $urandom_range(0, 1));
        end

        while (stim_q.size() > 0)
        begin
            burst = (stim_q.size() > 0 && $urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
            for (int b = 0; b < burst && stim_q.size() > 0; b++)
            begin
                it = stim_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.data;
                s_axis_tuser  <= it.present;
                s_axis_tlast  <= it.eom;
                @(posedge clk);
                while (!s_axis_tready)
                    @(posedge clk);
                absorb(it);
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        all_sent = 1'b1;
    end

    // Receiver: stall pattern driven by a slowly varying mode
    initial
    begin
        int mode;
        m_axis_tready = 1'b0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Digest checker
    always @(posedge clk)
    begin
        digest_out_t want;
        logic [32:0] kn;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_words++;
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h", m_axis_tdata);
                n_errors++;
            end
            else
            begin
                want = digest_q.pop_front();
                if (m_axis_tdata !== want.word)
                begin
                    $error("digest_word expected %h actual %h", want.word, m_axis_tdata);
                    n_errors++;
                end
                if (m_axis_tuser !== want.idx)
                begin
                    $error("word_index expected %0d actual %0d", want.idx, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_word expected %0d actual %0d", want.last, m_axis_tlast);
                    n_errors++;
                end
                if (want.idx == 2'd0 && known_q.size() > 0)
                begin
                    kn = known_q.pop_front();
                    if (kn[32] && m_axis_tdata !== kn[31:0])
                    begin
                        $error("digest_word expected %h actual %h", kn[31:0], m_axis_tdata);
                        n_errors++;
                    end
                end
                if (want.last)
                    n_msgs++;
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > MAX_CYCLES)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        n_errors = 0;
        n_words  = 0;
        n_msgs   = 0;
        wait (all_sent);
        while (digest_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("%0d messages hashed, %0d digest words checked", n_msgs, n_words);
        if (n_errors == 0 && digest_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Round constants: floor(abs(sin(i + 1)) * 2^32)
    initial
    begin
        for (int r = 0; r < 64; r++)
            addend[r] = 32'(longint'($floor((($sin(r + 1.0) < 0) ? -$sin(r + 1.0)
                                                               : $sin(r + 1.0)) * 4294967296.0)));
    end
endmodule
`default_nettype wire
